// ===== hw/rtl/glcd_pkg.sv =====
package glcd_pkg;

   localparam int SEGMENTS  = 3;
   localparam int COLUMNS   = 64;
   localparam int PAGES     = 8;
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int PAGE_W    = $clog2(PAGES);
   localparam int SEG_WORDS = COLUMNS * PAGES;
   localparam int MADDR_W   = COL_W + PAGE_W;
   localparam int SEG_IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

   localparam logic [15:0] BASE_RESET = 16'h9020;

   // control port bits
   localparam logic [7:0] CTL_RUN = 8'h10;
   localparam logic [7:0] CTL_E   = 8'h04;

   // command codes
   localparam logic [7:0] CMD_ON_LO   = 8'h3E;
   localparam logic [7:0] CMD_COL_LO  = 8'h40;
   localparam logic [7:0] CMD_COL_END = 8'h80;
   localparam logic [7:0] CMD_PAGE_LO = 8'hB8;
   localparam logic [7:0] CMD_LINE_LO = 8'hC0;
   localparam logic [7:0] STATUS_ON   = 8'h20;

   // {rw, rs}
   typedef enum logic [1:0] {
      MODE_CMD    = 2'b00,
      MODE_STORE  = 2'b01,
      MODE_STATUS = 2'b10,
      MODE_READ   = 2'b11
   } mode_type;

   typedef struct packed {
      logic               we;
      logic [MADDR_W-1:0] addr;
      logic [7:0]         wdata;
   } mem_req_type;

   // active-low select line of each segment, none for a fourth segment
   function automatic logic [7:0] select_mask(input int s);
      logic [7:0] m;
      m = 8'h00;
      unique case (s)
         0: m = 8'h08;
         1: m = 8'h20;
         2: m = 8'h40;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/glcd_ram.sv =====
module glcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== hw/rtl/glcd_ctrl.sv =====
module glcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 req_type,
   input  logic [15:0]          address,
   input  logic [7:0]           value,
   input  logic [15:0]          base_address,
   input  logic [7:0]           mem_q   [glcd_pkg::SEGMENTS],
   output glcd_pkg::mem_req_type mem_req [glcd_pkg::SEGMENTS],
   output logic [7:0]           read_data,
   output logic                 hit
);
   import glcd_pkg::*;

   logic [7:0]           latch_ff, latch_in;
   logic                 held_ff, held_in;
   logic                 en_ff, en_in;
   logic                 pend_ff, pend_in;
   logic [SEG_IDX_W-1:0] pend_seg_ff, pend_seg_in;
   logic                 on_ff   [SEGMENTS];
   logic                 on_in   [SEGMENTS];
   logic [COL_W-1:0]     col_ff  [SEGMENTS];
   logic [COL_W-1:0]     col_in  [SEGMENTS];
   logic [PAGE_W-1:0]    page_ff [SEGMENTS];
   logic [PAGE_W-1:0]    page_in [SEGMENTS];
   logic [COL_W-1:0]     line_ff [SEGMENTS];
   logic [COL_W-1:0]     line_in [SEGMENTS];

   logic [7:0]  latch_eff;
   logic [15:0] cport;

   always_comb begin
      logic [SEGMENTS-1:0] sel;
      logic                falling;
      logic                all_on;
      mode_type            mode;
      logic [7:0]          d;

      sel     = '0;
      falling = 1'b0;
      all_on  = 1'b1;
      mode    = MODE_CMD;

      // a display read of the previous word lands here
      latch_eff = pend_ff ? mem_q[pend_seg_ff] : latch_ff;
      d         = latch_eff;
      cport     = base_address + 16'd1;
      hit       = (address == base_address) || (address == cport);
      read_data = '0;

      latch_in    = latch_eff;
      held_in     = held_ff;
      en_in       = en_ff;
      pend_in     = 1'b0;
      pend_seg_in = pend_seg_ff;
      for (int s = 0; s < SEGMENTS; s++) begin
         on_in[s]   = on_ff[s];
         col_in[s]  = col_ff[s];
         page_in[s] = page_ff[s];
         line_in[s] = line_ff[s];
      end

      if (accept && hit) begin
         if (req_type) begin
            read_data = latch_eff;
         end else if (address == cport) begin
            if ((value & CTL_RUN) == '0) begin
               held_in = 1'b1;
            end else begin
               if (held_ff) begin
                  for (int s = 0; s < SEGMENTS; s++) begin
                     on_in[s]   = 1'b0;
                     col_in[s]  = '0;
                     page_in[s] = '0;
                     line_in[s] = '0;
                  end
               end
               held_in = 1'b0;
               for (int s = 0; s < SEGMENTS; s++) begin
                  sel[s] = (select_mask(s) != '0) && ((value & select_mask(s)) == '0);
               end
               falling = en_ff && ((value & CTL_E) == '0);
               en_in   = ((value & CTL_E) != '0);
               mode    = mode_type'(value[1:0]);
            end
         end else if (!held_ff) begin
            latch_in = value;
         end
      end

      // memory address from the pointers before this word moves them
      for (int s = 0; s < SEGMENTS; s++) begin
         mem_req[s].we    = 1'b0;
         mem_req[s].addr  = {page_in[s], col_in[s]};
         mem_req[s].wdata = d;
         all_on           = all_on & on_in[s];
      end

      if (falling) begin
         unique case (mode)
            MODE_CMD: begin
               for (int s = 0; s < SEGMENTS; s++) begin
                  if (sel[s]) begin
                     if (d >= CMD_ON_LO && d < CMD_COL_LO) begin
                        on_in[s] = d[0];
                     end else if (d >= CMD_COL_LO && d < CMD_COL_END) begin
                        col_in[s] = d[COL_W-1:0];
                     end else if (d >= CMD_PAGE_LO && d < CMD_LINE_LO) begin
                        page_in[s] = d[PAGE_W-1:0];
                     end else if (d >= CMD_LINE_LO) begin
                        line_in[s] = d[COL_W-1:0];
                     end
                  end
               end
            end
            MODE_STATUS: begin
               latch_in = all_on ? STATUS_ON : 8'h00;
            end
            MODE_STORE: begin
               for (int s = 0; s < SEGMENTS; s++) begin
                  if (sel[s]) begin
                     mem_req[s].we = 1'b1;
                     col_in[s]     = col_in[s] + 1'b1;
                  end
               end
            end
            MODE_READ: begin
               // highest selected segment wins
               for (int s = 0; s < SEGMENTS; s++) begin
                  if (sel[s]) begin
                     pend_in     = 1'b1;
                     pend_seg_in = SEG_IDX_W'(s);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff    <= '0;
         held_ff     <= 1'b1;
         en_ff       <= 1'b0;
         pend_ff     <= 1'b0;
         pend_seg_ff <= '0;
         for (int s = 0; s < SEGMENTS; s++) begin
            on_ff[s]   <= 1'b0;
            col_ff[s]  <= '0;
            page_ff[s] <= '0;
            line_ff[s] <= '0;
         end
      end else begin
         latch_ff    <= latch_in;
         held_ff     <= held_in;
         en_ff       <= en_in;
         pend_ff     <= pend_in;
         pend_seg_ff <= pend_seg_in;
         for (int s = 0; s < SEGMENTS; s++) begin
            on_ff[s]   <= on_in[s];
            col_ff[s]  <= col_in[s];
            page_ff[s] <= page_in[s];
            line_ff[s] <= line_in[s];
         end
      end
   end

endmodule

// ===== hw/rtl/graphic_lcd_controller_model_unit.sv =====
// graphic lcd controller, three segments, on a processor bus
// req channel: one bus access per word (req_type 0 write / 1 read, address,
// value). the block answers at base_address (data latch) and the next
// address (control port); every access gives one rsp word with rsp_hit and
// rsp_read_data (the latch for a read that hits, else zero).
// csr port: csr_write_enable / csr_write_data set base_address, while idle.
// throughput: one word per cycle while req_stall is low. the rsp word is valid
// the cycle after acceptance, from an output register. a display read fetches
// from the per-segment display ram (registered read) and the byte is forwarded
// into the latch path for the very next word, so no bubble is needed.
// reset: synchronous, active high. all segment registers and the latch clear,
// then a clearing pass writes zero through the display ram, one address of
// every segment per cycle, with req_stall held high; csr writes are still
// taken during the pass.
// when rsp_stall holds a waiting word, req_stall rises in the same cycle and
// the waiting word is kept unchanged until taken.
module graphic_lcd_controller_model_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_hit,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import glcd_pkg::*;

   logic [15:0]          base_ff;
   logic                 clearing_ff;
   logic [MADDR_W-1:0]   clr_cnt_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff;
   logic                 rsp_hit_ff;

   logic                 accept;
   logic [7:0]           read_data;
   logic                 hit;
   mem_req_type          mem_req [SEGMENTS];
   mem_req_type          ram_req [SEGMENTS];
   logic [7:0]           mem_q   [SEGMENTS];

   assign req_stall = clearing_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   glcd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .address      (req_address),
      .value        (req_value),
      .base_address (base_ff),
      .mem_q        (mem_q),
      .mem_req      (mem_req),
      .read_data    (read_data),
      .hit          (hit)
   );

   always_comb begin
      for (int s = 0; s < SEGMENTS; s++) begin
         if (clearing_ff) begin
            ram_req[s].we    = 1'b1;
            ram_req[s].addr  = clr_cnt_ff;
            ram_req[s].wdata = '0;
         end else begin
            ram_req[s] = mem_req[s];
         end
      end
   end

   for (genvar g = 0; g < SEGMENTS; g++) begin : g_seg
      glcd_ram #(
         .WIDTH (8),
         .DEPTH (SEG_WORDS)
      ) u_ram (
         .clock (clock),
         .we    (ram_req[g].we),
         .addr  (ram_req[g].addr),
         .wdata (ram_req[g].wdata),
         .rdata (mem_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == MADDR_W'(SEG_WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= read_data;
         rsp_hit_ff  <= hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_hit       = rsp_hit_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

import glcd_pkg::*;

// active-low select line of segments 0, 1, 2
localparam logic [2:0][7:0] SEL_LINE = {8'h40, 8'h20, 8'h08};
localparam logic ACC_WRITE = 1'b0;
localparam logic ACC_READ  = 1'b1;

class lcd_scoreboard;
   typedef struct {
      logic [7:0] data;
      logic       hit;
   } reply_type;

   logic [15:0]       base_addr;
   logic [7:0]        latch;
   bit                held;
   bit                e_level;
   bit [SEGMENTS-1:0] seg_on;
   logic [COL_W-1:0]  column [SEGMENTS];
   logic [PAGE_W-1:0] page [SEGMENTS];
   logic [COL_W-1:0]  start_row [SEGMENTS];
   logic [7:0]        pixels [SEGMENTS*SEG_WORDS];
   reply_type         replies [$];
   int                errors;
   int                checked;
   int                commands;
   int                stores;
   int                fetches;

   function new();
      base_addr = BASE_RESET;
      latch     = 8'h00;
      held      = 1'b1;
      e_level   = 1'b0;
      seg_on    = '0;
      foreach (column[s]) begin
         column[s]    = '0;
         page[s]      = '0;
         start_row[s] = '0;
      end
      foreach (pixels[i])
         pixels[i] = 8'h00;
      errors   = 0;
      checked  = 0;
      commands = 0;
      stores   = 0;
      fetches  = 0;
   endfunction

   function int pending();
      return replies.size();
   endfunction

   // runs the latched byte on the falling edge of E
   function void execute(bit [SEGMENTS-1:0] sel, mode_type m);
      logic [7:0] d;
      int         idx;
      d = latch;
      case (m)
         MODE_CMD: begin
            commands++;
            for (int s = 0; s < SEGMENTS; s++) begin
               if (!sel[s])
                  continue;
               if (d >= CMD_ON_LO && d < CMD_COL_LO)
                  seg_on[s] = d[0];
               else if (d >= CMD_COL_LO && d < CMD_COL_END)
                  column[s] = d[5:0];
               else if (d >= CMD_PAGE_LO && d < CMD_LINE_LO)
                  page[s] = d[2:0];
               else if (d >= CMD_LINE_LO)
                  start_row[s] = d[5:0];
            end
         end
         MODE_STATUS:
            latch = (&seg_on) ? STATUS_ON : 8'h00;
         MODE_STORE: begin
            stores++;
            for (int s = 0; s < SEGMENTS; s++) begin
               if (!sel[s])
                  continue;
               idx = s * SEG_WORDS + int'(page[s]) * COLUMNS + int'(column[s]);
               pixels[idx] = d;
               column[s]   = column[s] + 1'b1;
            end
         end
         default: begin
            fetches++;
            // highest selected segment wins, none leaves the latch alone
            for (int s = 0; s < SEGMENTS; s++) begin
               if (!sel[s])
                  continue;
               idx   = s * SEG_WORDS + int'(page[s]) * COLUMNS + int'(column[s]);
               latch = pixels[idx];
            end
         end
      endcase
   endfunction

   function void control_word(logic [7:0] v);
      bit [SEGMENTS-1:0] sel;
      bit                falling;
      if ((v & CTL_RUN) == 8'h00) begin
         held = 1'b1;
         return;
      end
      // leaving reset clears the segment registers, not the display store
      if (held) begin
         seg_on = '0;
         foreach (column[s]) begin
            column[s]    = '0;
            page[s]      = '0;
            start_row[s] = '0;
         end
      end
      held = 1'b0;
      for (int s = 0; s < SEGMENTS; s++)
         sel[s] = (v & SEL_LINE[s]) == 8'h00;
      falling = e_level && ((v & CTL_E) == 8'h00);
      e_level = (v & CTL_E) != 8'h00;
      if (falling)
         execute(sel, mode_type'(v[1:0]));
   endfunction

   function void note_access(logic kind, logic [15:0] addr, logic [7:0] value);
      reply_type   want;
      logic [15:0] ctl_addr;
      ctl_addr  = base_addr + 16'd1;
      want.hit  = (addr == base_addr) || (addr == ctl_addr);
      want.data = 8'h00;
      if (want.hit) begin
         if (kind == ACC_READ)
            want.data = latch;
         else if (addr == ctl_addr)
            control_word(value);
         else if (!held)
            latch = value;
      end
      replies.push_back(want);
   endfunction

   function void check_reply(logic [7:0] data, logic hit);
      reply_type want;
      checked++;
      if (replies.size() == 0) begin
         $display("%0t: reply with none expected: read_data %02h hit %0b", $time, data, hit);
         errors++;
         return;
      end
      want = replies.pop_front();
      if (hit !== want.hit) begin
         $display("%0t: hit expected %0b, actual %0b", $time, want.hit, hit);
         errors++;
      end
      if (data !== want.data) begin
         $display("%0t: read_data expected %02h, actual %02h", $time, want.data, data);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_type         = ACC_WRITE;
   logic [15:0] req_address      = 16'h0000;
   logic [7:0]  req_value        = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_hit;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = 16'h0000;

   bit            idle_on       = 1'b1;
   int            hold_requests = 0;
   int            holds_done    = 0;
   int            stall_left    = 0;
   int            words_sent    = 0;
   lcd_scoreboard sb            = new();

   graphic_lcd_controller_model_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_hit          (rsp_hit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_access(req_type, req_address, req_value);
         if (rsp_valid && !rsp_stall)
            sb.check_reply(rsp_read_data, rsp_hit);
      end
   end

   // receiver: short random stall bursts, and a long hold-off when asked
   always @(negedge clock) begin
      if (holds_done != hold_requests) begin
         holds_done = holds_done + 1;
         stall_left = 240;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else
         rsp_stall <= 1'b0;
   end

   // called just after a falling edge, returns just after a falling edge once the word has been accepted
   task automatic send_access(input logic kind, input logic [15:0] addr,
                              input logic [7:0] value);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_address <= addr;
      req_value   <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // latch the byte for a command or store, pulse E with the chosen selects, read back for a status or read
   task automatic lcd_op(input mode_type m, input logic [2:0] sel, input logic [7:0] value);
      logic [7:0] ctl;
      ctl = CTL_RUN | CTL_E | {6'b000000, m};
      for (int s = 0; s < SEGMENTS; s++)
         if (!sel[s])
            ctl = ctl | SEL_LINE[s];
      if (m == MODE_CMD || m == MODE_STORE)
         send_access(ACC_WRITE, sb.base_addr, value);
      send_access(ACC_WRITE, sb.base_addr + 16'd1, ctl);
      send_access(ACC_WRITE, sb.base_addr + 16'd1, ctl & ~CTL_E);
      if (m == MODE_STATUS || m == MODE_READ)
         send_access(ACC_READ, sb.base_addr, value);
   endtask

   task automatic write_base(input logic [15:0] b);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= b;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.base_addr = b;
   endtask

   initial begin
      logic [15:0] bases [6];
      int          target;
      int          pick;
      mode_type    m;
      logic [7:0]  d;
      logic [2:0]  sel;
      logic        kind;
      logic [15:0] addr;
      bases[0] = BASE_RESET;
      bases[1] = 16'h0000;
      bases[2] = 16'hFFFF;
      bases[3] = 16'hFFFE;
      bases[4] = 16'($urandom_range(1, 16'hFFFD));
      bases[5] = 16'($urandom_range(1, 16'hFFFD));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_access(ACC_READ, BASE_RESET, 8'h5A);
      send_access(ACC_WRITE, BASE_RESET, 8'hAA);   // dropped, still held in reset
      lcd_op(MODE_CMD, 3'b111, 8'h3F);
      lcd_op(MODE_STATUS, 3'b111, 8'h00);
      lcd_op(MODE_CMD, 3'b111, 8'hBF);
      lcd_op(MODE_CMD, 3'b111, 8'h7F);
      lcd_op(MODE_STORE, 3'b001, 8'hFF);           // last column, wraps to 0
      send_access(ACC_WRITE, BASE_RESET + 16'd1, 8'h00);
      lcd_op(MODE_READ, 3'b000, 8'h00);            // no chip selected, latch kept

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0)
            write_base(bases[phase]);
         idle_on = (phase != 5);
         if (phase == 1 || phase == 3)
            hold_requests++;
         target = words_sent + 195;
         while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            sel  = ($urandom_range(0, 3) == 0) ? 3'b111 : 3'($urandom_range(0, 7));
            d    = 8'($urandom_range(0, 255));
            kind = 1'($urandom_range(0, 1));
            if (pick < 72) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: m = MODE_STORE;
                  3, 4:    m = MODE_READ;
                  5:       m = MODE_STATUS;
                  default: m = MODE_CMD;
               endcase
               if (m == MODE_CMD)
                  case ($urandom_range(0, 4))
                     0: d = CMD_ON_LO | {7'd0, d[0]};
                     1: d = CMD_COL_LO | {2'd0, d[5:0]};
                     2: d = CMD_PAGE_LO | {5'd0, d[2:0]};
                     3: d = CMD_LINE_LO | {2'd0, d[5:0]};
                     default: ;
                  endcase
               lcd_op(m, sel, d);
            end else if (pick < 82) begin
               addr = sb.base_addr + 16'($urandom_range(0, 1));
               send_access(kind, addr, d);
            end else if (pick < 88)
               send_access(ACC_WRITE, sb.base_addr + 16'd1, d);
            else begin
               case ($urandom_range(0, 2))
                  0:       addr = sb.base_addr - 16'd1;
                  1:       addr = sb.base_addr + 16'd2;
                  default: addr = 16'($urandom_range(0, 16'hFFFF));
               endcase
               send_access(kind, addr, d);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      $display("covered %0d bus words over 6 base addresses, %0d replies checked",
               words_sent, sb.checked);
      $display("executed %0d commands, %0d display stores, %0d display fetches",
               sb.commands, sb.stores, sb.fetches);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/glcd_pkg.sv
hw/rtl/glcd_ram.sv
hw/rtl/glcd_ctrl.sv
hw/rtl/graphic_lcd_controller_model_unit.sv
test/tb_top.sv
